>>> design/lbp_pkg.sv
// Shared types, counter codes and the counter update function for the
// local-history branch predictor. No dependencies.
package lbp_pkg;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_STRONG_NT  = 2'b00;
   localparam ctr_type CTR_WEAK_NT    = 2'b01;
   localparam ctr_type CTR_WEAK_TAKEN = 2'b10;
   localparam ctr_type CTR_STRONG_T   = 2'b11;

   // 2-bit saturating counter step
   function automatic ctr_type ctr_update(input ctr_type ctr, input logic taken);
      ctr_type nxt;
      nxt = ctr;
      if (taken) begin
         if (ctr != CTR_STRONG_T) nxt = ctr + 2'd1;
      end else begin
         if (ctr != CTR_STRONG_NT) nxt = ctr - 2'd1;
      end
      return nxt;
   endfunction

endpackage

>>> design/lbp_hist_stage.sv
// History stage: per-branch history memory, read-modify-write with bypass.
// Depends on lbp_pkg.
module lbp_hist_stage import lbp_pkg::*; #(
   parameter int COUNTER_INDEX_BITS = 12,
   parameter int HISTORY_INDEX_BITS = 8,
   parameter int HISTORY_BITS       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [31:0]                   in_addr,
   input  logic                          in_taken,
   input  logic                          clr_active,
   input  logic [HISTORY_INDEX_BITS-1:0] clr_index,
   output logic                          s1_valid,
   output logic [COUNTER_INDEX_BITS-1:0] s1_pc,
   output logic [HISTORY_BITS-1:0]       s1_hist,
   output logic                          s1_taken
);

   logic [HISTORY_BITS-1:0] hist_mem [2**HISTORY_INDEX_BITS];

   logic                          s1_valid_ff, s1_valid_in;
   logic [HISTORY_INDEX_BITS-1:0] s1_hsel_ff;
   logic [COUNTER_INDEX_BITS-1:0] s1_pc_ff;
   logic                          s1_taken_ff;
   logic [HISTORY_BITS-1:0]       s1_hist_ff;

   logic [HISTORY_INDEX_BITS-1:0] in_hsel;
   logic [HISTORY_BITS:0]         hist_shift;
   logic [HISTORY_BITS-1:0]       hist_new;
   logic                          bypass;

   logic                          wr_en;
   logic [HISTORY_INDEX_BITS-1:0] wr_addr;
   logic [HISTORY_BITS-1:0]       wr_data;

   assign in_hsel    = in_addr[HISTORY_INDEX_BITS+1:2];
   assign hist_shift = {s1_hist_ff, s1_taken_ff};
   assign hist_new   = hist_shift[HISTORY_BITS-1:0];
   // older item in s1 writes the same entry at this edge
   assign bypass     = s1_valid_ff && (s1_hsel_ff == in_hsel);

   always_comb begin
      if (clr_active) begin
         wr_en   = 1'b1;
         wr_addr = clr_index;
         wr_data = '0;
      end else begin
         wr_en   = advance && s1_valid_ff;
         wr_addr = s1_hsel_ff;
         wr_data = hist_new;
      end
   end

   assign s1_valid_in = advance ? in_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) hist_mem[wr_addr] <= wr_data;
      if (advance) begin
         s1_hist_ff  <= bypass ? hist_new : hist_mem[in_hsel];
         s1_hsel_ff  <= in_hsel;
         s1_pc_ff    <= in_addr[COUNTER_INDEX_BITS+1:2];
         s1_taken_ff <= in_taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_pc    = s1_pc_ff;
   assign s1_hist  = s1_hist_ff;
   assign s1_taken = s1_taken_ff;

endmodule

>>> design/lbp_ctr_stage.sv
// Counter stage: pattern table of 2-bit counters, read-modify-write with bypass.
// Depends on lbp_pkg.
module lbp_ctr_stage import lbp_pkg::*; #(
   parameter int COUNTER_INDEX_BITS = 12,
   parameter int HISTORY_BITS       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          s1_valid,
   input  logic [COUNTER_INDEX_BITS-1:0] s1_pc,
   input  logic [HISTORY_BITS-1:0]       s1_hist,
   input  logic                          s1_taken,
   input  logic                          clr_active,
   input  logic [COUNTER_INDEX_BITS-1:0] clr_index,
   output logic                          s2_valid,
   output logic                          s2_predict
);

   ctr_type ctr_mem [2**COUNTER_INDEX_BITS];

   logic                          s2_valid_ff, s2_valid_in;
   logic [COUNTER_INDEX_BITS-1:0] s2_cidx_ff;
   logic                          s2_taken_ff;
   ctr_type                       s2_ctr_ff;

   // pc bits above the history; slice keeps only the low index bits
   logic [COUNTER_INDEX_BITS+HISTORY_BITS-1:0] idx_cat;
   logic [COUNTER_INDEX_BITS-1:0]              cidx;
   ctr_type                                    ctr_new;
   logic                                       bypass;

   logic                          wr_en;
   logic [COUNTER_INDEX_BITS-1:0] wr_addr;
   ctr_type                       wr_data;

   assign idx_cat = {s1_pc, s1_hist};
   assign cidx    = idx_cat[COUNTER_INDEX_BITS-1:0];
   assign ctr_new = ctr_update(s2_ctr_ff, s2_taken_ff);
   assign bypass  = s2_valid_ff && (s2_cidx_ff == cidx);

   always_comb begin
      if (clr_active) begin
         wr_en   = 1'b1;
         wr_addr = clr_index;
         wr_data = CTR_WEAK_TAKEN;
      end else begin
         wr_en   = advance && s2_valid_ff;
         wr_addr = s2_cidx_ff;
         wr_data = ctr_new;
      end
   end

   assign s2_valid_in = advance ? s1_valid : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) ctr_mem[wr_addr] <= wr_data;
      if (advance) begin
         s2_ctr_ff   <= bypass ? ctr_new : ctr_mem[cidx];
         s2_cidx_ff  <= cidx;
         s2_taken_ff <= s1_taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign s2_valid   = s2_valid_ff;
   assign s2_predict = s2_ctr_ff[1];

endmodule

>>> design/two_level_local_branch_predictor.sv
// Top level of the two-level local-history branch predictor: clearing pass,
// pipeline control and result register. Depends on lbp_pkg, lbp_hist_stage, lbp_ctr_stage.
//
//   channel | dir | beat contents
//   req     | in  | tdata[31:0] branch_address, tdata[32] was_taken
//   rsp     | out | tdata[0] predict_taken
//
// One branch per cycle while the pipe advances; a beat's history is read into s1 at the
// accepting edge, its counter into s2, and its prediction into the result register (rsp).
// After reset both tables are swept, one entry a cycle, as the clear counter steps
// through 2**max(COUNTER_INDEX_BITS, HISTORY_INDEX_BITS) indices (4096 at defaults);
// req_tready stays low meanwhile.
// A result held in the output register with rsp_tready low freezes the whole
// pipe, memory writes included, and drops req_tready.
module two_level_local_branch_predictor import lbp_pkg::*; #(
   parameter int COUNTER_INDEX_BITS = 12,
   parameter int HISTORY_INDEX_BITS = 8,
   parameter int HISTORY_BITS       = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] branch_address, [32] was_taken
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] predict_taken
);

   localparam int CLR_BITS = (COUNTER_INDEX_BITS > HISTORY_INDEX_BITS) ?
                             COUNTER_INDEX_BITS : HISTORY_INDEX_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CLR_BITS-1:0]  clr_ff, clr_in;
   logic                 clr_active;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pred_ff;

   logic                 advance;
   logic                 in_valid;

   logic                          s1_valid;
   logic [COUNTER_INDEX_BITS-1:0] s1_pc;
   logic [HISTORY_BITS-1:0]       s1_hist;
   logic                          s1_taken;
   logic                          s2_valid;
   logic                          s2_predict;

   assign clr_active = (state_ff == ST_CLEAR);

   // whole pipe moves when the result register is empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !clr_active;
   assign in_valid   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {CLR_BITS{1'b1}}) state_in = ST_RUN;
         end
         ST_RUN: begin
            clr_in = clr_ff;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = advance ? s2_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) rsp_pred_ff <= s2_predict;
   end

   lbp_hist_stage #(
      .COUNTER_INDEX_BITS (COUNTER_INDEX_BITS),
      .HISTORY_INDEX_BITS (HISTORY_INDEX_BITS),
      .HISTORY_BITS       (HISTORY_BITS)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_addr    (req_tdata[31:0]),
      .in_taken   (req_tdata[32]),
      .clr_active (clr_active),
      .clr_index  (clr_ff[HISTORY_INDEX_BITS-1:0]),
      .s1_valid   (s1_valid),
      .s1_pc      (s1_pc),
      .s1_hist    (s1_hist),
      .s1_taken   (s1_taken)
   );

   lbp_ctr_stage #(
      .COUNTER_INDEX_BITS (COUNTER_INDEX_BITS),
      .HISTORY_BITS       (HISTORY_BITS)
   ) u_ctr (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_pc      (s1_pc),
      .s1_hist    (s1_hist),
      .s1_taken   (s1_taken),
      .clr_active (clr_active),
      .clr_index  (clr_ff[COUNTER_INDEX_BITS-1:0]),
      .s2_valid   (s2_valid),
      .s2_predict (s2_predict)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pred_ff};

endmodule
